[design/polyline_length_splitter_top_defines.svh]
// Assertion macros for the polyline length splitter.
// Used by the top level; needs clk and rst_n in the including scope.
`ifndef POLYLINE_LENGTH_SPLITTER_TOP_DEFINES_SVH
`define POLYLINE_LENGTH_SPLITTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Assert an implication property on the block clock.
`define PLS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert that a condition never holds.
`define PLS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PLS_ASSERT(lbl, prop, msg)
`define PLS_NEVER(lbl, cond, msg)
`endif
`endif

[design/pls_pkg.sv]
// Package for the polyline length splitter: constants, register map, state type.
// No dependencies.
package pls_pkg;
    localparam int PLS_COORD_WIDTH = 32;
    localparam int PLS_FRAC_BITS   = 16;
    localparam int PLS_MAX_SPLITS  = 31;
    localparam int PLS_CFG_WIDTH   = 32;
    localparam logic [PLS_CFG_WIDTH-1:0] PLS_SPLIT_RESET = 32'd100000;
    // register index of split_length
    localparam logic PLS_REG_SPLIT_LENGTH = 1'b0;

    typedef enum logic [4:0] {
        S_IDLE, S_SQX_LD, S_SQX, S_SQY_LD, S_SQY, S_SQRT_LD, S_SQRT, S_ROUND,
        S_SUM, S_CNT, S_CUT, S_IM_LD, S_IM, S_ID_LD, S_ID, S_IQ, S_CHK,
        S_CUTEND, S_TAIL, S_APP, S_FIN
    } pls_state_t;
endpackage

[design/pls_vtx_if.sv]
// Vertex input channel: valid/ready handshake with x, y and first_point.
// Depends on nothing.
interface pls_vtx_if #(parameter int CW = 32);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 first_point;
    modport source (output valid, x, y, first_point, input ready);
    modport sink   (input valid, x, y, first_point, output ready);
endinterface

[design/pls_pt_if.sv]
// Point output channel: valid/ready handshake with the emitted point and flags.
// Depends on nothing.
interface pls_pt_if #(parameter int CW = 32);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic                 piece_start;
    logic                 last_of_run;
    logic                 overflow;
    modport source (output valid, out_x, out_y, piece_start, last_of_run, overflow,
                    input ready);
    modport sink   (input valid, out_x, out_y, piece_start, last_of_run, overflow,
                    output ready);
endinterface

[design/polyline_length_splitter_top.sv]
// Polyline length splitter: takes one vertex per beat and emits points that cut each
// line into pieces no longer than split_length. A vertex with no cut needs two
// shift-add multiplies and a square root; each cut adds two multiplies and two
// divides, and a trailing distance another two multiplies and a square root. A vertex
// is capped at MAX_SPLITS cuts (31 at defaults). Output back-pressure can stall it
// further. All of it runs on one shift-add multiplier, one digit-by-digit square root
// and one restoring divider under the sequencer; the input is ready only while idle,
// so a new vertex is not taken before the last one is through. A first vertex of a
// line is taken without leaving idle and produces no beat.
// Depends on pls_pkg, pls_vtx_if, pls_pt_if and polyline_length_splitter_top_defines.svh.
`include "polyline_length_splitter_top_defines.svh"
module polyline_length_splitter_top #(
    parameter int COORD_WIDTH = pls_pkg::PLS_COORD_WIDTH,
    parameter int FRAC_BITS   = pls_pkg::PLS_FRAC_BITS,
    parameter int MAX_SPLITS  = pls_pkg::PLS_MAX_SPLITS
) (
    input  logic        clk,
    input  logic        rst_n,
    pls_vtx_if.sink     vtx_in,
    pls_pt_if.source    pt_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [pls_pkg::PLS_CFG_WIDTH-1:0] pwdata,
    output logic [pls_pkg::PLS_CFG_WIDTH-1:0] prdata,
    output logic        pready
);
    import pls_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int FB   = FRAC_BITS;
    localparam int DMW  = CW + 1;
    localparam int DW   = CW + FB + 2;
    localparam int RW   = DW;
    localparam int VPW  = 2 * RW;
    localparam int LW   = PLS_CFG_WIDTH + FB;
    localparam int RUNW = (DW > LW) ? DW : LW;
    localparam int SUMW = RUNW + 1;
    localparam int AW   = SUMW + 1;
    localparam int CNTW = $clog2(MAX_SPLITS + 2);
    localparam int MAW  = DMW + DW;
    localparam int QW   = CW + 2;
    localparam int XW   = DW + CW + 3;
    localparam int ITW  = $clog2(RW + 1);
    localparam logic [CNTW-1:0] MS_C = CNTW'(MAX_SPLITS);

    pls_state_t state_reg, state_next;

    // configuration
    logic [PLS_CFG_WIDTH-1:0] split_reg;
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == PLS_REG_SPLIT_LENGTH);
    assign prdata = (paddr[2] == PLS_REG_SPLIT_LENGTH) ? split_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            split_reg <= PLS_SPLIT_RESET;
        else if (cfg_wr)
            split_reg <= (pwdata == '0) ? PLS_CFG_WIDTH'(1) : pwdata;
    end

    logic [LW-1:0] lf;
    assign lf = {split_reg, {FB{1'b0}}};

    // datapath registers
    logic signed [CW-1:0] prev_x_reg, prev_y_reg, cur_x_reg, cur_y_reg;
    logic signed [CW-1:0] held_x_reg, held_y_reg, ix_reg, iy_reg, app_x_reg, app_y_reg;
    logic signed [CW-1:0] prev_x_next, prev_y_next, cur_x_next, cur_y_next;
    logic signed [CW-1:0] held_x_next, held_y_next, ix_next, iy_next, app_x_next, app_y_next;
    logic held_valid_reg, held_valid_next, line_active_reg, line_active_next;
    logic dist_sel_reg, dist_sel_next, axis_reg, axis_next, app_ret_reg, app_ret_next;
    logic ovf_reg, ovf_next;
    logic [RUNW-1:0] run_reg, run_next;
    logic [DW-1:0]   delta_reg, delta_next;
    logic [SUMW-1:0] sum_reg, sum_next, m_reg, m_next;
    logic [AW-1:0]   acc_reg, acc_next;
    logic [CNTW-1:0] cuts_reg, cuts_next, j_reg, j_next;
    logic [ITW-1:0]  it_reg, it_next;
    logic [MAW-1:0]  mc_reg, mc_next, macc_reg, macc_next;
    logic [DMW-1:0]  mp_reg, mp_next;
    logic [VPW-1:0]  v_reg, v_next;
    logic [RW+1:0]   srem_reg, srem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [XW-1:0]   drem_reg, drem_next, dsh_reg, dsh_next;
    logic [QW-1:0]   q_reg, q_next;
    // pending point and output register
    logic signed [CW-1:0] pend_x_reg, pend_y_reg, pend_x_next, pend_y_next;
    logic pend_valid_reg, pend_valid_next, pend_start_reg, pend_start_next;
    logic pend_ovf_reg, pend_ovf_next;
    logic signed [CW-1:0] ox_reg, oy_reg, ox_next, oy_next;
    logic ov_reg, ov_next, ostart_reg, ostart_next, olast_reg, olast_next;
    logic oovf_reg, oovf_next;

    // shared combinational helpers
    logic in_fire, slot_free, app_go, new_line, cnt_go, sum_gt, pt_eq;
    logic signed [CW:0] diff_x, diff_y, diff_a;
    logic [DMW-1:0] mag_x, mag_y;
    logic [DW-1:0] num, root_rnd;
    logic [SUMW-1:0] sum_w;
    logic [RW+3:0] remsh, trial;
    logic sq_ge, dv_ge;
    logic signed [CW+1:0] ipt;
    logic signed [CW-1:0] prev_a;

    assign in_fire   = vtx_in.valid && vtx_in.ready;
    assign slot_free = !ov_reg || pt_out.ready;
    assign app_go    = !pend_valid_reg || slot_free;
    assign new_line  = vtx_in.first_point || !line_active_reg;
    assign cnt_go    = (cuts_reg <= MS_C) && (acc_reg <= AW'(sum_reg));
    assign sum_w     = SUMW'(run_reg) + SUMW'(delta_reg);
    assign sum_gt    = sum_w > SUMW'(lf);
    assign pt_eq     = (ix_reg == cur_x_reg) && (iy_reg == cur_y_reg);

    assign diff_x = {cur_x_reg[CW-1], cur_x_reg}
                  - (dist_sel_reg ? {ix_reg[CW-1], ix_reg} : {prev_x_reg[CW-1], prev_x_reg});
    assign diff_y = {cur_y_reg[CW-1], cur_y_reg}
                  - (dist_sel_reg ? {iy_reg[CW-1], iy_reg} : {prev_y_reg[CW-1], prev_y_reg});
    assign mag_x  = diff_x[CW] ? DMW'(-diff_x) : DMW'(diff_x);
    assign mag_y  = diff_y[CW] ? DMW'(-diff_y) : DMW'(diff_y);
    assign diff_a = axis_reg ? diff_y : diff_x;
    assign prev_a = axis_reg ? prev_y_reg : prev_x_reg;
    // the quotient never exceeds the axis magnitude, so its top bit is always clear
    assign ipt    = diff_a[CW]
                  ? ({{2{prev_a[CW-1]}}, prev_a} - $signed({1'b0, q_reg[QW-2:0]}))
                  : ({{2{prev_a[CW-1]}}, prev_a} + $signed({1'b0, q_reg[QW-2:0]}));

    assign num      = DW'(m_reg - SUMW'(run_reg));
    assign remsh    = {srem_reg, v_reg[VPW-1:VPW-2]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign sq_ge    = remsh >= trial;
    assign dv_ge    = dsh_reg <= drem_reg;
    assign root_rnd = root_reg + DW'(srem_reg > (RW+2)'(root_reg));

    assign vtx_in.ready       = (state_reg == S_IDLE);
    assign pt_out.valid       = ov_reg;
    assign pt_out.out_x       = ox_reg;
    assign pt_out.out_y       = oy_reg;
    assign pt_out.piece_start = ostart_reg;
    assign pt_out.last_of_run = olast_reg;
    assign pt_out.overflow    = oovf_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (in_fire && !new_line) state_next = S_SQX_LD;
            S_SQX_LD:  state_next = S_SQX;
            S_SQX:     if (it_reg == '0) state_next = S_SQY_LD;
            S_SQY_LD:  state_next = S_SQY;
            S_SQY:     if (it_reg == '0) state_next = S_SQRT_LD;
            S_SQRT_LD: state_next = S_SQRT;
            S_SQRT:    if (it_reg == '0) state_next = S_ROUND;
            S_ROUND:   state_next = dist_sel_reg ? S_APP : S_SUM;
            S_SUM:     state_next = sum_gt ? S_CNT : S_APP;
            S_CNT:     if (!cnt_go) state_next = S_CUT;
            S_CUT:     state_next = S_IM_LD;
            S_IM_LD:   state_next = S_IM;
            S_IM:      if (it_reg == '0) state_next = S_ID_LD;
            S_ID_LD:   state_next = S_ID;
            S_ID:      if (it_reg == '0) state_next = S_IQ;
            S_IQ:      state_next = axis_reg ? S_CHK : S_IM_LD;
            S_CHK:     state_next = (num != '0) ? S_APP : S_CUTEND;
            S_CUTEND:  state_next = (j_reg < cuts_reg) ? S_CUT : S_TAIL;
            S_TAIL:    state_next = pt_eq ? S_FIN : S_SQX_LD;
            S_APP:     if (app_go && !held_valid_reg)
                           state_next = app_ret_reg ? S_FIN : S_CUTEND;
            S_FIN:     if (app_go) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and output next values
    always_comb
    begin
        prev_x_next = prev_x_reg;   prev_y_next = prev_y_reg;
        cur_x_next = cur_x_reg;     cur_y_next = cur_y_reg;
        held_x_next = held_x_reg;   held_y_next = held_y_reg;
        ix_next = ix_reg;           iy_next = iy_reg;
        app_x_next = app_x_reg;     app_y_next = app_y_reg;
        held_valid_next = held_valid_reg;
        line_active_next = line_active_reg;
        dist_sel_next = dist_sel_reg;
        axis_next = axis_reg;
        app_ret_next = app_ret_reg;
        ovf_next = ovf_reg;
        run_next = run_reg;         delta_next = delta_reg;
        sum_next = sum_reg;         m_next = m_reg;
        acc_next = acc_reg;         cuts_next = cuts_reg;
        j_next = j_reg;             it_next = it_reg;
        mc_next = mc_reg;           macc_next = macc_reg;  mp_next = mp_reg;
        v_next = v_reg;             srem_next = srem_reg;  root_next = root_reg;
        drem_next = drem_reg;       dsh_next = dsh_reg;    q_next = q_reg;
        pend_x_next = pend_x_reg;   pend_y_next = pend_y_reg;
        pend_valid_next = pend_valid_reg;
        pend_start_next = pend_start_reg;
        pend_ovf_next = pend_ovf_reg;
        ox_next = ox_reg;           oy_next = oy_reg;
        ostart_next = ostart_reg;   olast_next = olast_reg;  oovf_next = oovf_reg;
        // drop the output beat once taken
        ov_next = ov_reg && !pt_out.ready;

        unique case (state_reg) inside
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cur_x_next = vtx_in.x;
                    cur_y_next = vtx_in.y;
                    ovf_next = 1'b0;
                    dist_sel_next = 1'b0;
                    if (new_line)
                    begin
                        line_active_next = 1'b1;
                        prev_x_next = vtx_in.x;
                        prev_y_next = vtx_in.y;
                        run_next = '0;
                        held_x_next = vtx_in.x;
                        held_y_next = vtx_in.y;
                        held_valid_next = 1'b1;
                    end
                end
            end
            S_SQX_LD, S_SQY_LD:
            begin
                mc_next = MAW'((state_reg == S_SQX_LD) ? mag_x : mag_y);
                mp_next = (state_reg == S_SQX_LD) ? mag_x : mag_y;
                if (state_reg == S_SQX_LD)
                    macc_next = '0;
                it_next = ITW'(DMW - 1);
            end
            S_SQX, S_SQY, S_IM:
            begin
                // shift-add multiply step
                if (mp_reg[0])
                    macc_next = macc_reg + mc_reg;
                mc_next = {mc_reg[MAW-2:0], 1'b0};
                mp_next = {1'b0, mp_reg[DMW-1:1]};
                it_next = it_reg - 1'b1;
            end
            S_SQRT_LD:
            begin
                v_next = VPW'(macc_reg) << (2 * FB);
                srem_next = '0;
                root_next = '0;
                it_next = ITW'(RW - 1);
            end
            S_SQRT:
            begin
                // one root digit per cycle
                srem_next = sq_ge ? (RW+2)'(remsh - trial) : (RW+2)'(remsh);
                root_next = {root_reg[RW-2:0], sq_ge};
                v_next = {v_reg[VPW-3:0], 2'b00};
                it_next = it_reg - 1'b1;
            end
            S_ROUND:
            begin
                if (!dist_sel_reg)
                    delta_next = root_rnd;
                else
                begin
                    run_next = (RUNW'(root_rnd) > RUNW'(lf)) ? RUNW'(lf) : RUNW'(root_rnd);
                    app_x_next = cur_x_reg;
                    app_y_next = cur_y_reg;
                    app_ret_next = 1'b1;
                end
            end
            S_SUM:
            begin
                sum_next = sum_w;
                acc_next = AW'(lf);
                cuts_next = '0;
                // no cut: carry the run length and append the vertex
                if (!sum_gt)
                begin
                    run_next = RUNW'(sum_w);
                    app_x_next = cur_x_reg;
                    app_y_next = cur_y_reg;
                    app_ret_next = 1'b1;
                end
            end
            S_CNT:
            begin
                if (cnt_go)
                begin
                    cuts_next = cuts_reg + 1'b1;
                    acc_next = acc_reg + AW'(lf);
                end
                else if (cuts_reg > MS_C)
                begin
                    cuts_next = MS_C;
                    ovf_next = 1'b1;
                end
                m_next = '0;
                j_next = '0;
            end
            S_CUT:
            begin
                m_next = m_reg + SUMW'(lf);
                j_next = j_reg + 1'b1;
                axis_next = 1'b0;
            end
            S_IM_LD:
            begin
                mc_next = MAW'(num);
                mp_next = axis_reg ? mag_y : mag_x;
                macc_next = '0;
                it_next = ITW'(DMW - 1);
            end
            S_ID_LD:
            begin
                drem_next = XW'({macc_reg, 1'b0}) + XW'(delta_reg);
                dsh_next = XW'(delta_reg) << QW;
                q_next = '0;
                it_next = ITW'(QW - 1);
            end
            S_ID:
            begin
                // restoring divide step
                if (dv_ge)
                    drem_next = drem_reg - dsh_reg;
                q_next = {q_reg[QW-2:0], dv_ge};
                dsh_next = {1'b0, dsh_reg[XW-1:1]};
                it_next = it_reg - 1'b1;
            end
            S_IQ:
            begin
                if (axis_reg)
                    iy_next = CW'(ipt);
                else
                    ix_next = CW'(ipt);
                axis_next = 1'b1;
            end
            S_CHK:
            begin
                app_x_next = ix_reg;
                app_y_next = iy_reg;
                app_ret_next = 1'b0;
            end
            S_CUTEND:
            begin
                held_x_next = ix_reg;
                held_y_next = iy_reg;
                held_valid_next = 1'b1;
            end
            S_TAIL:
            begin
                if (pt_eq)
                    run_next = '0;
                else
                    dist_sel_next = 1'b1;
            end
            S_APP:
            begin
                // push held start first, then the point itself
                if (app_go)
                begin
                    if (pend_valid_reg)
                    begin
                        ov_next = 1'b1;
                        ox_next = pend_x_reg;
                        oy_next = pend_y_reg;
                        ostart_next = pend_start_reg;
                        olast_next = 1'b0;
                        oovf_next = pend_ovf_reg;
                    end
                    pend_valid_next = 1'b1;
                    pend_ovf_next = ovf_reg;
                    pend_start_next = held_valid_reg;
                    pend_x_next = held_valid_reg ? held_x_reg : app_x_reg;
                    pend_y_next = held_valid_reg ? held_y_reg : app_y_reg;
                    held_valid_next = 1'b0;
                end
            end
            S_FIN:
            begin
                prev_x_next = cur_x_reg;
                prev_y_next = cur_y_reg;
                if (pend_valid_reg && slot_free)
                begin
                    ov_next = 1'b1;
                    ox_next = pend_x_reg;
                    oy_next = pend_y_reg;
                    ostart_next = pend_start_reg;
                    olast_next = 1'b1;
                    oovf_next = pend_ovf_reg;
                    pend_valid_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            held_valid_reg  <= 1'b0;
            line_active_reg <= 1'b0;
            pend_valid_reg  <= 1'b0;
            ov_reg          <= 1'b0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            held_x_reg      <= '0;
            held_y_reg      <= '0;
            run_reg         <= '0;
            cuts_reg        <= '0;
            j_reg           <= '0;
            it_reg          <= '0;
            dist_sel_reg    <= 1'b0;
            axis_reg        <= 1'b0;
            app_ret_reg     <= 1'b0;
            ovf_reg         <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            held_valid_reg  <= held_valid_next;
            line_active_reg <= line_active_next;
            pend_valid_reg  <= pend_valid_next;
            ov_reg          <= ov_next;
            prev_x_reg      <= prev_x_next;
            prev_y_reg      <= prev_y_next;
            held_x_reg      <= held_x_next;
            held_y_reg      <= held_y_next;
            run_reg         <= run_next;
            cuts_reg        <= cuts_next;
            j_reg           <= j_next;
            it_reg          <= it_next;
            dist_sel_reg    <= dist_sel_next;
            axis_reg        <= axis_next;
            app_ret_reg     <= app_ret_next;
            ovf_reg         <= ovf_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_x_reg <= cur_x_next;   cur_y_reg <= cur_y_next;
        ix_reg <= ix_next;         iy_reg <= iy_next;
        app_x_reg <= app_x_next;   app_y_reg <= app_y_next;
        delta_reg <= delta_next;   sum_reg <= sum_next;
        m_reg <= m_next;           acc_reg <= acc_next;
        mc_reg <= mc_next;         macc_reg <= macc_next;  mp_reg <= mp_next;
        v_reg <= v_next;           srem_reg <= srem_next;  root_reg <= root_next;
        drem_reg <= drem_next;     dsh_reg <= dsh_next;    q_reg <= q_next;
        pend_x_reg <= pend_x_next; pend_y_reg <= pend_y_next;
        pend_start_reg <= pend_start_next;
        pend_ovf_reg <= pend_ovf_next;
        ox_reg <= ox_next;         oy_reg <= oy_next;
        ostart_reg <= ostart_next; olast_reg <= olast_next;  oovf_reg <= oovf_next;
    end

    // checks on the sequencer
    `PLS_NEVER(a_idle_pend, (state_reg == S_IDLE) && pend_valid_reg, "pending point in idle")
    `PLS_ASSERT(a_cut_cap, (state_reg != S_CNT) |-> (cuts_reg <= MS_C), "cut count above cap")
    `PLS_ASSERT(a_cut_hold, (state_reg == S_CUTEND) |=> held_valid_reg, "cut point not held")
endmodule
